// File: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by tcw_dp, tcw_ctrl and text_console_writer.
`default_nettype none
package tcw_pkg;

  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  localparam logic [CHAR_W-1:0] CELL_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_ACCESS,
    ST_COPY,
    ST_ZERO,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic calc;
    logic access;
    logic cnt_clear;
    logic copy_step;
    logic zero_step;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic do_scroll;
    logic copy_done;
    logic zero_last;
    logic clr_last;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/tcw_dp.sv
// Datapath of the text console writer: config, cursor, address maths,
// sweep counter and the screen RAM. Depends on tcw_pkg and tcw_ram.
`default_nettype none
module tcw_dp #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  wire tcw_pkg::item_t                    item,
  input  wire tcw_pkg::cmd_t                     cmd,
  output tcw_pkg::stat_t                         stat,
  output tcw_pkg::result_t                       result
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int ColW  = tcw_pkg::COL_W;
  localparam int RowW  = tcw_pkg::ROW_W;

  logic [ColW-1:0] screen_width;
  logic [RowW-1:0] screen_height;
  logic [ColW-1:0] eff_w;
  logic [RowW-1:0] eff_h;
  logic [CntW-1:0] bot_base;

  tcw_pkg::item_t  item_q;
  logic [ColW-1:0] cursor_x;
  logic [RowW-1:0] cursor_y;

  logic [AddrW-1:0] addr;
  logic             in_range;
  logic             wr;
  logic             scr;
  logic [ColW-1:0]  nx;
  logic [RowW-1:0]  ny;

  logic [ColW-1:0]  x_cl;
  logic [RowW-1:0]  y_cl;
  logic [RowW-1:0]  row_sel;
  logic [ColW-1:0]  col_sel;
  logic [AddrW-1:0] prod;
  logic [AddrW-1:0] sum;
  logic [ColW:0]    x1;
  logic [RowW:0]    y1;
  logic             wr_next;
  logic             scr_next;
  logic             in_range_next;

  logic [CntW-1:0]  cnt;
  logic             pend;
  logic [AddrW-1:0] pend_addr;
  logic             copy_more;

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [AddrW-1:0]            ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  // config registers; height keeps the low five bits of cfg_data; zero counts as one, large values limit to the maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 7'd80;
      screen_height <= 5'd25;
    end else if (cfg_we) begin
      if (cfg_index == tcw_pkg::REG_SCREEN_WIDTH) begin
        screen_width <= cfg_data;
      end else if (cfg_index == tcw_pkg::REG_SCREEN_HEIGHT) begin
        screen_height <= cfg_data[RowW-1:0];
      end
    end
  end

  always_comb begin
    if (screen_width == '0) begin
      eff_w = ColW'(1);
    end else if (int'(screen_width) > MAX_COLS) begin
      eff_w = ColW'(MAX_COLS);
    end else begin
      eff_w = screen_width;
    end
    if (screen_height == '0) begin
      eff_h = RowW'(1);
    end else if (int'(screen_height) > MAX_ROWS) begin
      eff_h = RowW'(MAX_ROWS);
    end else begin
      eff_h = screen_height;
    end
  end

  // start of the bottom row; also the number of cells moved by a scroll
  always_ff @(posedge clk) begin
    bot_base <= CntW'(eff_h - RowW'(1)) * CntW'(eff_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
  end

  always_comb begin
    x_cl = (cursor_x > eff_w - ColW'(1)) ? eff_w - ColW'(1) : cursor_x;
    y_cl = (cursor_y > eff_h - RowW'(1)) ? eff_h - RowW'(1) : cursor_y;
    row_sel = (item_q.mode == tcw_pkg::MODE_READ) ? item_q.read_row : y_cl;
    col_sel = (item_q.mode == tcw_pkg::MODE_READ) ? item_q.read_col : x_cl;
    prod = AddrW'(row_sel) * AddrW'(eff_w);
    sum  = prod + AddrW'(col_sel);
    in_range_next = (item_q.read_row < eff_h) && (item_q.read_col < eff_w);

    wr_next  = 1'b0;
    scr_next = 1'b0;
    if (item_q.char_code == tcw_pkg::CH_CR) begin
      x1 = '0;
      y1 = {1'b0, y_cl};
    end else if (item_q.char_code == tcw_pkg::CH_LF) begin
      x1 = '0;
      y1 = {1'b0, y_cl} + (RowW+1)'(1);
    end else begin
      x1 = {1'b0, x_cl} + (ColW+1)'(1);
      y1 = {1'b0, y_cl};
      wr_next = 1'b1;
    end
    if (x1 >= {1'b0, eff_w}) begin
      x1 = '0;
      y1 = y1 + (RowW+1)'(1);
    end
    if (y1 >= {1'b0, eff_h}) begin
      y1 = {1'b0, eff_h - RowW'(1)};
      scr_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr     <= sum;
      in_range <= in_range_next;
      wr       <= wr_next;
      scr      <= scr_next;
      nx       <= x1[ColW-1:0];
      ny       <= y1[RowW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (cmd.access && item_q.mode == tcw_pkg::MODE_PUT) begin
      cursor_x <= nx;
      cursor_y <= ny;
    end
  end

  // one counter serves the reset sweep, the row copy and the bottom-row clear
  assign copy_more = cnt < bot_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.cnt_clear) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.clr_step || cmd.zero_step) begin
      cnt <= cnt + CntW'(1);
    end else if (cmd.copy_step) begin
      pend <= copy_more;
      if (copy_more) begin
        cnt <= cnt + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step) begin
      pend_addr <= cnt[AddrW-1:0];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {tcw_pkg::CELL_ATTR, item_q.char_code};
    priority if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[AddrW-1:0];
      ram_wdata = '0;
    end else if (cmd.zero_step) begin
      ram_we    = 1'b1;
      ram_waddr = AddrW'(bot_base + cnt);
      ram_wdata = '0;
    end else if (pend) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.access && item_q.mode == tcw_pkg::MODE_PUT) begin
      ram_we = wr;
    end

    ram_re    = 1'b0;
    ram_raddr = addr;
    priority if (cmd.access && item_q.mode == tcw_pkg::MODE_READ) begin
      ram_re = in_range;
    end else if (cmd.copy_step && copy_more) begin
      ram_re    = 1'b1;
      ram_raddr = AddrW'(cnt + CntW'(eff_w));
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.cell_value <= (item_q.mode == tcw_pkg::MODE_READ && in_range) ? ram_rdata : '0;
      result.cursor_col <= cursor_x;
      result.cursor_row <= cursor_y;
      result.scrolled   <= (item_q.mode == tcw_pkg::MODE_PUT) && scr;
    end
  end

  assign stat.is_read   = (item_q.mode == tcw_pkg::MODE_READ);
  assign stat.do_scroll = scr;
  assign stat.copy_done = !copy_more && !pend;
  assign stat.zero_last = (cnt == CntW'(eff_w) - CntW'(1));
  assign stat.clr_last  = (cnt == CntW'(Depth - 1));

endmodule
`default_nettype wire

// File: rtl/core/tcw_ctrl.sv
// Sequencer of the text console writer: handshakes and datapath commands.
// Depends on tcw_pkg.
`default_nettype none
module tcw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  output logic                 result_valid,
  input  wire logic            result_ready,
  input  wire tcw_pkg::stat_t  stat,
  output tcw_pkg::cmd_t        cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_CLEAR:  if (stat.clr_last) state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_IDLE:   if (item_valid) state_next = tcw_pkg::ST_CALC;
      tcw_pkg::ST_CALC:   state_next = tcw_pkg::ST_ACCESS;
      tcw_pkg::ST_ACCESS: begin
        if (!stat.is_read && stat.do_scroll) state_next = tcw_pkg::ST_COPY;
        else state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_COPY:   if (stat.copy_done) state_next = tcw_pkg::ST_ZERO;
      tcw_pkg::ST_ZERO:   if (stat.zero_last) state_next = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE:   if (out_free) state_next = tcw_pkg::ST_IDLE;
      default:            state_next = tcw_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      tcw_pkg::ST_CLEAR: begin
        cmd.clr_step  = 1'b1;
        cmd.cnt_clear = 1'b0;
      end
      tcw_pkg::ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_item = item_valid;
      end
      tcw_pkg::ST_CALC: cmd.calc = 1'b1;
      tcw_pkg::ST_ACCESS: begin
        cmd.access    = 1'b1;
        cmd.cnt_clear = 1'b1;
      end
      tcw_pkg::ST_COPY: begin
        // counter restarts for the bottom-row clear once the copy drains
        cmd.copy_step = !stat.copy_done;
        cmd.cnt_clear = stat.copy_done;
      end
      tcw_pkg::ST_ZERO: cmd.zero_step = 1'b1;
      tcw_pkg::ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/text_console_writer.sv
// Text console writer. An item passes CALC, ACCESS and DONE; the result is
// registered on leaving DONE, which waits while the output is held. A scroll
// copies (height-1)*width cells up a row and clears the bottom row, a cell at
// a time via the single RAM write port. One item at a time; after reset the
// MAX_COLS*MAX_ROWS (2000 by default) cells are zeroed with item_ready low.
// Depends on tcw_pkg, tcw_ctrl, tcw_dp and tcw_ram.
`default_nettype none
module text_console_writer #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire tcw_pkg::item_t                 item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output tcw_pkg::result_t                    result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tcw_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  // one item in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous item in progress");

  // a put never returns cell data, a read never scrolls
  a_cell_or_scroll: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cell_value != '0 |-> !result.scrolled)
    else $error("result with both cell data and scroll");

  a_cursor_col: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> int'(result.cursor_col) < MAX_COLS)
    else $error("cursor column beyond screen");

  a_cursor_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> int'(result.cursor_row) < MAX_ROWS)
    else $error("cursor row beyond screen");

endmodule
`default_nettype wire
